>>> src/tpmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tpmq_pkg;
  localparam int QueueDepth = 16;
  localparam int AddrBits   = $clog2(QueueDepth);
  localparam int CntBits    = $clog2(QueueDepth + 1);
  localparam int TagBits    = 16;

  localparam logic [1:0] RegEnable  = 2'd0;
  localparam logic [1:0] RegLimit   = 2'd1;
  localparam logic [1:0] RegTimeout = 2'd2;
  localparam logic [1:0] RegTipThr  = 2'd3;

  localparam logic [2:0] EvQueued   = 3'd0;
  localparam logic [2:0] EvFull     = 3'd1;
  localparam logic [2:0] EvDisabled = 3'd2;
  localparam logic [2:0] EvTimeout  = 3'd3;
  localparam logic [2:0] EvDispatch = 3'd4;

  typedef struct packed {
    logic [31:0]        stamp;
    logic [2:0]         prio;
    logic [TagBits-1:0] tag;
  } entry_t;
endpackage
`default_nettype wire

>>> src/tiered_priority_message_queue_top.sv
// Tiered priority message queue.
// Input stream: tuser carries cmd (0 enqueue, 1 server done); tdata carries the
// message fields. Each input gives zero or more result items on the output
// stream, tlast marking the final result of that input; tuser is the event code.
// Entries live in a 16-entry synchronous RAM used as a ring (head pointer).
// An enqueue walks from the tail toward the head, reading each entry and then
// comparing it and moving it one place toward the tail, until it reaches the head
// or stops at an entry of equal or higher priority. Each pop at dispatch reads
// the head entry and then waits for the output register to be free; up to 17
// results per input. The input is taken only while the sequencer is idle
// and the output register is free. Reset empties the queue, clears the busy
// flag and loads register defaults (disabled, limit 16, timeout 30000, tip
// threshold 10000). While the receiver stalls, the pending result is held in
// the output register, the sequencer waits before producing the next one and
// the input is held off.
`timescale 1ns / 1ps
`default_nettype none
module tiered_priority_message_queue_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] message_tag, [16] is_paid, [40:17] tip_cents, [43:41] user_tier,
  // [75:44] now_ticks, [79:76] zero
  input  wire logic [79:0] s_axis_tdata,
  // [0] cmd
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] out_tag, [18:16] out_priority, [23:19] queue_count
  output logic [23:0]      m_axis_tdata,
  // [2:0] event_res
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import tpmq_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StIns   = 3'd3;
  localparam logic [2:0] StPop   = 3'd4;
  localparam logic [2:0] StPopCk = 3'd5;

  entry_t mem_q [QueueDepth];
  entry_t rd_q;

  logic [2:0]          state_q, state_d;
  logic [AddrBits-1:0] head_q, head_d;
  logic [CntBits-1:0]  count_q, count_d;
  logic [CntBits-1:0]  idx_q, idx_d;
  logic                busy_q, busy_d;
  entry_t              new_q, new_d;

  logic        en_q;
  logic [4:0]  limit_q;
  logic [31:0] timeout_q;
  logic [23:0] tipthr_q;

  logic        ovalid_q, ovalid_d;
  logic [23:0] odata_q, odata_d;
  logic [2:0]  ouser_q, ouser_d;
  logic        olast_q, olast_d;

  logic                rd_en, wr_en;
  logic [AddrBits-1:0] rd_addr, wr_addr;
  entry_t              wr_data;

  logic        out_free;
  logic [2:0]  in_prio;
  logic [CntBits-1:0] eff_limit;
  logic [31:0] age;
  logic [CntBits-1:0] idx_m1;

  assign out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;
  assign idx_m1 = idx_q - CntBits'(1);
  assign age = new_q.stamp - rd_q.stamp;
  assign eff_limit = (CntBits'(limit_q) > CntBits'(QueueDepth)) ?
                     CntBits'(QueueDepth) : CntBits'(limit_q);

  always_comb begin
    if (s_axis_tdata[16]) begin
      in_prio = (s_axis_tdata[40:17] >= tipthr_q) ? 3'd4 : 3'd2;
    end else begin
      in_prio = (s_axis_tdata[43:41] <= 3'd4) ? s_axis_tdata[43:41] : 3'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    idx_d    = idx_q;
    busy_d   = busy_q;
    new_d    = new_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    ouser_d  = ouser_q;
    olast_d  = olast_q;
    rd_en    = 1'b0;
    rd_addr  = head_q + idx_m1[AddrBits-1:0];
    wr_en    = 1'b0;
    wr_addr  = head_q + idx_q[AddrBits-1:0];
    wr_data  = rd_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && out_free) begin
          new_d.tag   = s_axis_tdata[TagBits-1:0];
          new_d.prio  = in_prio;
          new_d.stamp = s_axis_tdata[75:44];
          if (s_axis_tuser) begin
            busy_d  = 1'b0;
            state_d = StPop;
          end else if (!en_q || count_q >= eff_limit) begin
            // rejected enqueue: single result
            ovalid_d = 1'b1;
            ouser_d  = en_q ? EvFull : EvDisabled;
            odata_d  = {5'(count_q), in_prio, s_axis_tdata[15:0]};
            olast_d  = 1'b1;
          end else begin
            idx_d   = count_q;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (idx_q == '0) begin
          state_d = StIns;
        end else begin
          rd_en   = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (rd_q.prio < new_q.prio) begin
          // move the lower-priority entry one place toward the tail
          wr_en   = 1'b1;
          idx_d   = idx_m1;
          state_d = StScan;
        end else begin
          state_d = StIns;
        end
      end
      StIns: begin
        if (out_free) begin
          wr_en    = 1'b1;
          wr_data  = new_q;
          count_d  = count_q + CntBits'(1);
          ovalid_d = 1'b1;
          ouser_d  = EvQueued;
          odata_d  = {5'(count_q + CntBits'(1)), new_q.prio, new_q.tag};
          olast_d  = busy_q;
          state_d  = busy_q ? StIdle : StPop;
        end
      end
      StPop: begin
        if (count_q == '0) begin
          state_d = StIdle;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = StPopCk;
        end
      end
      StPopCk: begin
        if (out_free) begin
          head_d   = head_q + AddrBits'(1);
          count_d  = count_q - CntBits'(1);
          ovalid_d = 1'b1;
          odata_d  = {5'(count_q - CntBits'(1)), rd_q.prio, rd_q.tag};
          if (age > timeout_q) begin
            ouser_d = EvTimeout;
            olast_d = (count_q == CntBits'(1));
            state_d = StPop;
          end else begin
            ouser_d = EvDispatch;
            olast_d = 1'b1;
            busy_d  = 1'b1;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      busy_q    <= 1'b0;
      ovalid_q  <= 1'b0;
      en_q      <= 1'b0;
      limit_q   <= 5'd16;
      timeout_q <= 32'd30000;
      tipthr_q  <= 24'd10000;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegEnable:  en_q      <= cfg_data_i[0];
          RegLimit:   limit_q   <= cfg_data_i[4:0];
          RegTimeout: timeout_q <= cfg_data_i;
          RegTipThr:  tipthr_q  <= cfg_data_i[23:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_q   <= new_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
    olast_q <= olast_d;
  end
endmodule
`default_nettype wire

>>> bench/tiered_priority_message_queue_top_test.sv
`timescale 1ns / 1ps
module tiered_priority_message_queue_top_test;
  import tpmq_pkg::*;

  localparam logic CmdEnq  = 1'b0;
  localparam logic CmdDone = 1'b1;
  localparam int MaxCycles = 2000000;

  typedef struct packed {
    logic        cmd;
    logic [15:0] tag;
    logic        paid;
    logic [23:0] tip;
    logic [2:0]  tier;
    logic [31:0] now;
  } msg_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [15:0] tag;
    logic [2:0]  prio;
    logic [4:0]  cnt;
    logic        last;
  } event_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [2:0]  prio;
    logic [31:0] stamp;
  } slot_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;

  tiered_priority_message_queue_top dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // shadow state of the queue
  slot_t       pq_slots[$];
  logic        pq_busy;
  logic        pq_enable;
  logic [4:0]  pq_limit;
  logic [31:0] pq_timeout;
  logic [23:0] pq_tip_thr;

  event_t event_q[$];
  msg_t   pending_q[$];
  int     errors = 0;
  int     cycles = 0;
  int     hold_off = 0;
  logic   in_fire = 0;

  task automatic emit_event(logic [2:0] ev, logic [15:0] tag, logic [2:0] prio);
    event_t e;
    e.ev = ev; e.tag = tag; e.prio = prio; e.cnt = 5'(pq_slots.size()); e.last = 0;
    event_q.push_back(e);
  endtask

  task automatic run_dispatch(logic [31:0] now);
    slot_t h;
    if (pq_busy) return;
    while (pq_slots.size() > 0) begin
      h = pq_slots.pop_front();
      if (32'(now - h.stamp) > pq_timeout) begin
        emit_event(EvTimeout, h.tag, h.prio);
      end else begin
        pq_busy = 1;
        emit_event(EvDispatch, h.tag, h.prio);
        break;
      end
    end
  endtask

  task automatic predict_events(msg_t m);
    int first;
    int pos;
    int lim;
    logic [2:0] prio;
    slot_t s;
    first = event_q.size();
    if (m.cmd == CmdDone) begin
      pq_busy = 0;
      run_dispatch(m.now);
    end else begin
      if (m.paid) prio = (m.tip >= pq_tip_thr) ? 3'd4 : 3'd2;
      else prio = (m.tier <= 4) ? m.tier : 3'd0;
      lim = (pq_limit < QueueDepth) ? pq_limit : QueueDepth;
      if (!pq_enable) begin
        emit_event(EvDisabled, m.tag, prio);
      end else if (pq_slots.size() >= lim) begin
        emit_event(EvFull, m.tag, prio);
      end else begin
        pos = 0;
        foreach (pq_slots[i]) begin
          if (prio > pq_slots[i].prio) break;
          pos = i + 1;
        end
        s.tag = m.tag; s.prio = prio; s.stamp = m.now;
        pq_slots.insert(pos, s);
        emit_event(EvQueued, m.tag, prio);
        run_dispatch(m.now);
      end
    end
    if (event_q.size() > first) event_q[event_q.size() - 1].last = 1;
  endtask

  // record the input handshake at the edge where it happens
  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
  end

  // driver: bursts with random gaps
  int gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) predict_events(pending_q.pop_front());
      if (!s_axis_tvalid || in_fire) begin
        if (gap > 0) begin
          gap <= gap - 1;
          s_axis_tvalid <= 0;
        end else if (pending_q.size() > 0) begin
          s_axis_tvalid <= 1;
          s_axis_tuser <= pending_q[0].cmd;
          s_axis_tdata <= {4'b0, pending_q[0].now, pending_q[0].tier, pending_q[0].tip,
                           pending_q[0].paid, pending_q[0].tag};
          if ($urandom_range(0, 5) == 0) gap <= $urandom_range(1, 12);
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else if (stall_phase[6]) begin
      m_axis_tready <= 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    event_t got;
    event_t want;
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[18:16], m_axis_tdata[23:19],
             m_axis_tlast};
      if (event_q.size() == 0) begin
        $error("unexpected result ev=%0d tag=%0h", got.ev, got.tag);
        errors++;
      end else begin
        want = event_q.pop_front();
        if (got.ev !== want.ev) begin
          $error("event_res exp %0d got %0d", want.ev, got.ev); errors++;
        end
        if (got.tag !== want.tag) begin
          $error("out_tag exp %0h got %0h", want.tag, got.tag); errors++;
        end
        if (got.prio !== want.prio) begin
          $error("out_priority exp %0d got %0d", want.prio, got.prio); errors++;
        end
        if (got.cnt !== want.cnt) begin
          $error("queue_count exp %0d got %0d", want.cnt, got.cnt); errors++;
        end
        if (got.last !== want.last) begin
          $error("last exp %0d got %0d", want.last, got.last); errors++;
        end
      end
    end
    if (cycles > MaxCycles) begin
      $display("FAILURE");
      $finish;
    end
  end

  logic [31:0] clock_now = 32'd1000;

  function automatic msg_t make_msg(logic cmd, logic [15:0] tag, logic paid, logic [23:0] tip,
                                    logic [2:0] tier, logic [31:0] now);
    msg_t m;
    m.cmd = cmd; m.tag = tag; m.paid = paid; m.tip = tip; m.tier = tier; m.now = now;
    return m;
  endfunction

  function automatic msg_t rand_msg(logic [31:0] ts);
    return make_msg($urandom_range(0, 3) == 0, 16'($urandom), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 20000)),
                    3'($urandom_range(0, 7)), ts);
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || s_axis_tvalid || event_q.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    case (idx)
      RegEnable:  pq_enable = val[0];
      RegLimit:   pq_limit = val[4:0];
      RegTimeout: pq_timeout = val;
      default:    pq_tip_thr = val[23:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  initial begin
    int n;
    pq_busy = 0; pq_enable = 0; pq_limit = 16; pq_timeout = 30000; pq_tip_thr = 10000;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // disabled enqueue, tier out of range, empty done
    pending_q.push_back(make_msg(CmdEnq, 16'hFFFF, 1, 24'hFFFFFF, 3'd7, 32'hFFFFFFFF));
    pending_q.push_back(make_msg(CmdDone, 16'h1234, 1, 24'h0, 3'd4, 32'd0));
    wait_drained();

    write_reg(RegEnable, 1);
    write_reg(RegTimeout, 0);
    write_reg(RegTipThr, 32'hFFFFFF);
    pending_q.push_back(make_msg(CmdEnq, 16'h0000, 0, 24'h0, 3'd0, 32'd10));
    pending_q.push_back(make_msg(CmdEnq, 16'h0001, 0, 24'h0, 3'd1, 32'd10));
    pending_q.push_back(make_msg(CmdEnq, 16'h0002, 0, 24'h0, 3'd2, 32'd11));
    pending_q.push_back(make_msg(CmdEnq, 16'h0003, 0, 24'h0, 3'd3, 32'd11));
    pending_q.push_back(make_msg(CmdEnq, 16'h0004, 0, 24'h0, 3'd4, 32'd12));
    pending_q.push_back(make_msg(CmdEnq, 16'h0005, 1, 24'hFFFFFE, 3'd5, 32'd12));
    pending_q.push_back(make_msg(CmdEnq, 16'h0006, 1, 24'hFFFFFF, 3'd6, 32'd12));
    pending_q.push_back(make_msg(CmdDone, 16'h0, 0, 24'h0, 3'd0, 32'd12));
    pending_q.push_back(make_msg(CmdDone, 16'h0, 0, 24'h0, 3'd0, 32'd13));
    wait_drained();

    write_reg(RegLimit, 0);
    pending_q.push_back(make_msg(CmdEnq, 16'hAAAA, 0, 24'h0, 3'd2, 32'd20));
    wait_drained();
    write_reg(RegLimit, 31);
    write_reg(RegTimeout, 32'hFFFFFFFF);
    write_reg(RegTipThr, 0);
    // fill while receiver holds off
    hold_off = 400;
    for (int i = 0; i < 20; i++)
      pending_q.push_back(make_msg(CmdEnq, 16'($urandom), 1, 24'h0, 3'($urandom), 32'd30));
    wait_drained();
    // receiver pause done: drain with dones
    for (int i = 0; i < 18; i++)
      pending_q.push_back(make_msg(CmdDone, 16'h0, 0, 24'h0, 3'd0, 32'd40));
    wait_drained();

    // random phases over several settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegLimit, (ph == 0) ? 32'd1 : 32'($urandom_range(2, 16)));
      write_reg(RegTimeout, (ph == 3) ? 32'd0 : 32'($urandom_range(5, 200)));
      write_reg(RegTipThr, 32'($urandom_range(0, 20000)));
      write_reg(RegEnable, 32'((ph != 2) || ($urandom_range(0, 1) == 1)));
      n = 0;
      while (n < 100) begin
        clock_now = clock_now + 32'($urandom_range(0, 40));
        if ($urandom_range(0, 20) == 0) clock_now = 32'hFFFFFFF0 + 32'($urandom_range(0, 15));
        pending_q.push_back(rand_msg(clock_now));
        n++;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
